/* rtl/core/maf_pkg.sv */
`timescale 1ns / 1ps

package maf_pkg;

	localparam int unsigned DEPTH = 8;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned SUM_W = 16 + $clog2(DEPTH);

	// floor(2^SUM_W / DEPTH): the quotient estimate is exact or one low
	localparam longint unsigned RECIP_INT = (64'd1 << SUM_W) / DEPTH;
	localparam logic [SUM_W-1:0] RECIP = SUM_W'(RECIP_INT);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_FILL   = 5'b00100,
		ST_DIVIDE = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [15:0]      data;
	} mem_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} mem_rd_t;

endpackage

/* rtl/core/maf_window.sv */
`timescale 1ns / 1ps

module maf_window (
	input  logic               clk,
	input  maf_pkg::mem_wr_t   wr,
	input  maf_pkg::mem_rd_t   rd,
	output logic signed [15:0] rd_data
);
	import maf_pkg::*;

	logic [15:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= signed'(mem_q[rd.addr]);
		end
	end

endmodule

/* rtl/core/moving_average_filter.sv */
`timescale 1ns / 1ps

// boxcar moving average over the last DEPTH signed 16-bit readings
// input channel (in_valid / in_ready): one word holds action and reading.
//   action 0 is a sample, action 1 arms a restart so the next sample
//   refills the whole window with its reading.
// output channel (out_valid / out_ready): one word per input word, holding
//   average (window sum / DEPTH, truncated toward zero) and newest (the
//   most recently stored reading).
// the window sits in a single-port-write RAM with a registered read; an
// ordinary sample reads the oldest entry, then writes the new reading.
// the result is registered after the states READ, DIVIDE and DONE for an
// ordinary sample, DIVIDE and DONE for an arm word, and FILL, DIVIDE and
// DONE for a restart sample (one RAM write per cycle to refill the window);
// the next word is taken the cycle after the result is registered, so a
// new word is never accepted while the last one is still in process.
// the divide is a reciprocal multiply with one correction step.
// reset leaves a restart armed and the sum at zero; no RAM clearing.
// if the receiver stalls, the result waits in the output register; one
// further word may be accepted and processed, then the block holds its
// result internally and keeps in_ready low until the output is taken.
module moving_average_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [15:0] reading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] average,
	output logic signed [15:0] newest
);
	import maf_pkg::*;

	localparam logic [SUM_W-1:0] DEP_U = SUM_W'(DEPTH);
	localparam logic signed [SUM_W-1:0] DEP_S = SUM_W'(DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

	state_t                   state_q;
	logic                     restart_q;
	logic [IDX_W-1:0]         wr_idx_q;
	logic [IDX_W-1:0]         fill_cnt_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [15:0]       sample_q;
	logic signed [15:0]       newest_q;
	logic [SUM_W-1:0]         mag_q;
	logic [SUM_W-1:0]         q0_q;
	logic                     neg_q;
	logic                     out_valid_q;
	logic signed [15:0]       average_q;
	logic signed [15:0]       newest_out_q;

	logic                     in_acc;
	logic                     out_free;
	logic signed [15:0]       rd_data;
	mem_wr_t                  mem_wr;
	mem_rd_t                  mem_rd;
	logic [SUM_W-1:0]         mag;
	logic [2*SUM_W-1:0]       prod;
	logic [SUM_W-1:0]         rem;
	logic [SUM_W-1:0]         quot;
	logic [SUM_W-1:0]         quot_signed;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign newest    = newest_out_q;

	always_comb begin
		mem_rd.en   = in_acc && !action && !restart_q;
		mem_rd.addr = wr_idx_q;
		mem_wr.en   = (state_q == ST_READ) || (state_q == ST_FILL);
		mem_wr.addr = (state_q == ST_FILL) ? fill_cnt_q : wr_idx_q;
		mem_wr.data = sample_q;
	end

	maf_window u_window (
		.clk     (clk),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.rd_data (rd_data)
	);

	// magnitude and reciprocal estimate
	assign mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign prod = {{SUM_W{1'b0}}, mag} * {{SUM_W{1'b0}}, RECIP};

	// correction of the estimate
	assign rem         = mag_q - SUM_W'(q0_q * DEP_U);
	assign quot        = (rem >= DEP_U) ? q0_q + 1'b1 : q0_q;
	assign quot_signed = neg_q ? SUM_W'(-quot) : quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			restart_q   <= 1'b1;
			wr_idx_q    <= '0;
			fill_cnt_q  <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (action) begin
							restart_q <= 1'b1;
							state_q   <= ST_DIVIDE;
						end else if (restart_q) begin
							restart_q  <= 1'b0;
							wr_idx_q   <= '0;
							fill_cnt_q <= '0;
							sum_q      <= SUM_W'(SUM_W'(reading) * DEP_S);
							state_q    <= ST_FILL;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					sum_q    <= sum_q - SUM_W'(rd_data) + SUM_W'(sample_q);
					wr_idx_q <= (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + 1'b1;
					state_q  <= ST_DIVIDE;
				end
				ST_FILL: begin
					fill_cnt_q <= fill_cnt_q + 1'b1;
					if (fill_cnt_q == IDX_LAST) begin
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= reading;
			if (!action) begin
				newest_q <= reading;
			end
		end
		if (state_q == ST_DIVIDE) begin
			mag_q <= mag;
			q0_q  <= prod[2*SUM_W-1:SUM_W];
			neg_q <= sum_q[SUM_W-1];
		end
		if ((state_q == ST_DONE) && out_free) begin
			average_q    <= signed'(quot_signed[15:0]);
			newest_out_q <= newest_q;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_idx_q <= IDX_LAST)
		else $error("write index out of range");

	a_arm_sets: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && action |=> restart_q)
		else $error("arm word did not set restart");

	a_sample_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !action |=> !restart_q)
		else $error("sample left restart pending");

	a_fill_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) && (fill_cnt_q != IDX_LAST) |=> (state_q == ST_FILL))
		else $error("window refill cut short");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_free |=> out_valid_q && (state_q == ST_IDLE))
		else $error("result not loaded into output register");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

	import maf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = DEPTH + 20;

	typedef enum logic {
		ACT_SAMPLE = 1'b0,
		ACT_ARM    = 1'b1
	} action_e;

	typedef struct {
		action_e            act;
		logic signed [15:0] rd;
		int unsigned        snd_pct;
		int unsigned        rcv_pct;
		bit                 hold;
	} word_t;

	typedef struct {
		logic signed [15:0] avg;
		logic signed [15:0] last;
	} avg_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = 1'b0;
	logic signed [15:0] reading = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] average;
	logic signed [15:0] newest;

	word_t       pending_words[$];
	avg_result_t expected_averages[$];

	// predictor state
	logic signed [15:0] ring [DEPTH];
	logic [IDX_W-1:0]   ring_idx;
	int                 ring_sum;
	bit                 refill_armed;

	int unsigned rcv_pct = 0;
	bit          hold_trigger = 1'b0;
	int unsigned hold_cnt = 0;
	int unsigned cycle_count = 0;
	int          errors = 0;

	moving_average_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.reading   (reading),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.average   (average),
		.newest    (newest)
	);

	always #5 clk = ~clk;

	function automatic avg_result_t update_average(action_e act, logic signed [15:0] rd);
		avg_result_t      r;
		logic [IDX_W-1:0] prev;
		if (act == ACT_ARM) begin
			refill_armed = 1'b1;
		end else if (refill_armed) begin
			for (int i = 0; i < DEPTH; i++)
				ring[i] = rd;
			ring_sum = int'(rd) * int'(DEPTH);
			ring_idx = '0;
			refill_armed = 1'b0;
		end else begin
			ring_sum = ring_sum - int'(ring[ring_idx]) + int'(rd);
			ring[ring_idx] = rd;
			ring_idx = (ring_idx == IDX_W'(DEPTH - 1)) ? '0 : ring_idx + 1'b1;
		end
		prev = (ring_idx == '0) ? IDX_W'(DEPTH - 1) : ring_idx - 1'b1;
		r.avg = 16'(ring_sum / int'(DEPTH));
		r.last = ring[prev];
		return r;
	endfunction

	task automatic push_word(action_e act, logic signed [15:0] rd, int unsigned snd,
			int unsigned rcv, bit hold);
		word_t w;
		w.act = act;
		w.rd = rd;
		w.snd_pct = snd;
		w.rcv_pct = rcv;
		w.hold = hold;
		pending_words.push_back(w);
	endtask

	function automatic logic signed [15:0] pick_reading();
		case ($urandom_range(15))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_phase(int n, int unsigned snd, int unsigned rcv);
		for (int i = 0; i < n; i++)
			push_word(($urandom_range(9) == 0) ? ACT_ARM : ACT_SAMPLE, pick_reading(),
				snd, rcv, 1'b0);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		word_t w;
		bit    trig;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_SAMPLE;
			reading <= '0;
			hold_trigger <= 1'b0;
		end else begin
			trig = 1'b0;
			if (in_valid && in_ready)
				expected_averages.push_back(update_average(action_e'(action), reading));
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 &&
						$urandom_range(99) >= pending_words[0].snd_pct) begin
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					action <= w.act;
					reading <= w.rd;
					rcv_pct <= w.rcv_pct;
					trig = w.hold;
				end else begin
					in_valid <= 1'b0;
				end
			end
			hold_trigger <= trig;
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_trigger)
			hold_cnt <= HOLD_CYCLES;
		else if (hold_cnt != 0)
			hold_cnt <= hold_cnt - 1;
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		avg_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_averages.size() == 0) begin
					$display("%0t: unexpected word: average %0d newest %0d",
						$time, average, newest);
					errors++;
				end else begin
					e = expected_averages.pop_front();
					if (average !== e.avg) begin
						$display("%0t: average mismatch: expected %0d actual %0d",
							$time, e.avg, average);
						errors++;
					end
					if (newest !== e.last) begin
						$display("%0t: newest mismatch: expected %0d actual %0d",
							$time, e.last, newest);
						errors++;
					end
				end
			end
			out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= rcv_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		ring_idx = '0;
		ring_sum = 0;
		refill_armed = 1'b1;

		// restart fill at max, then a full wrap of min samples
		push_word(ACT_SAMPLE, 16'sh7fff, 0, 0, 1'b0);
		for (int i = 0; i < 8; i++)
			push_word(ACT_SAMPLE, 16'sh8000, 0, 0, 1'b0);
		// double arm, refill with zero
		push_word(ACT_ARM, 16'sh1234, 0, 0, 1'b0);
		push_word(ACT_ARM, 16'shffff, 0, 0, 1'b0);
		push_word(ACT_SAMPLE, 16'sh0000, 0, 0, 1'b0);
		// small negative sums truncate toward zero
		push_word(ACT_SAMPLE, -16'sd1, 0, 0, 1'b0);
		push_word(ACT_SAMPLE, -16'sd3, 0, 0, 1'b0);
		push_word(ACT_SAMPLE, 16'sd7, 0, 0, 1'b0);
		push_word(ACT_SAMPLE, -16'sd9, 0, 0, 1'b0);
		push_word(ACT_SAMPLE, -16'sd5, 0, 0, 1'b0);
		push_word(ACT_ARM, 16'sh7fff, 0, 0, 1'b0);
		push_word(ACT_SAMPLE, 16'sh8000, 0, 0, 1'b0);
		push_word(ACT_SAMPLE, 16'sh7fff, 0, 0, 1'b0);

		add_phase(200, 0, 0);
		add_phase(200, 71, 0);
		add_phase(200, 0, 71);
		add_phase(200, 18, 18);
		push_word(ACT_SAMPLE, pick_reading(), 0, 0, 1'b1);
		add_phase(60, 0, 0);
		add_phase(40, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
